// File: rtl/core/efe_pkg.sv
// Shared types, constants and beat formats for the eased fade envelope.
package efe_pkg;

    // Default build parameters
    localparam int unsigned TIME_BITS_DEF     = 32;
    localparam int unsigned FRACTION_BITS_DEF = 16;

    // Field widths fixed by the register map and beat formats
    localparam int unsigned PHASE_W     = 24;
    localparam int unsigned END_W       = PHASE_W + 2;
    localparam int unsigned DELTA_W     = 16;
    localparam int unsigned ALPHA_W     = 8;
    localparam int unsigned CFG_INDEX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_DELAY = 3'd0,
        CFG_FADE_IN     = 3'd1,
        CFG_HOLD        = 3'd2,
        CFG_FADE_OUT    = 3'd3,
        CFG_PLAY_ONCE   = 3'd4
    } cfg_index_t;

    // Input beat
    typedef struct packed {
        logic               action;
        logic [DELTA_W-1:0] delta_ticks;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic               active;
    } out_beat_t;

    // Request to the serial ease unit
    typedef struct packed {
        logic               start;
        logic               fade_out;
        logic [PHASE_W-1:0] pos;
        logic [PHASE_W-1:0] len;
    } ease_cmd_t;

    // Answer from the serial ease unit
    typedef struct packed {
        logic               done;
        logic [ALPHA_W-1:0] alpha;
    } ease_rsp_t;

endpackage

// File: rtl/core/efe_ease.sv
// Bit-serial divider, squarer and alpha scaler for the quadratic ease.
module efe_ease #(
    parameter int unsigned FRACTION_BITS = efe_pkg::FRACTION_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  efe_pkg::ease_cmd_t cmd,
    output efe_pkg::ease_rsp_t rsp
);
    import efe_pkg::*;

    localparam int unsigned W     = FRACTION_BITS + 1;
    localparam int unsigned CNT_W = $clog2(W);
    localparam logic [W-1:0] FX_ONE = W'(1) << FRACTION_BITS;
    localparam logic [W:0]   FX_TWO = (W + 1)'(1) << (FRACTION_BITS + 1);

    typedef enum logic [2:0] {
        E_IDLE,
        E_DIV,
        E_PREP,
        E_MUL,
        E_SCALE
    } ease_state_t;

    ease_state_t              state_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [PHASE_W-1:0]       rem_reg;
    logic [PHASE_W-1:0]       len_reg;
    logic [FRACTION_BITS-1:0] quo_reg;
    logic                     fade_out_reg;
    logic                     lower_reg;
    logic [W-1:0]             mul_reg;
    logic [2*W-1:0]           prod_reg;
    logic [ALPHA_W-1:0]       alpha_reg;
    logic                     done_reg;

    logic [PHASE_W:0] rem_dbl;
    logic             rem_fit;
    logic [PHASE_W:0] rem_sub;
    logic [W:0]       u_full;
    logic [W-1:0]     mul_operand;
    logic [W:0]       prod_sum;
    logic [W-1:0]     e_low;
    logic [W-1:0]     e_high;
    logic [W-1:0]     ease_val;
    logic [W-1:0]     fade_val;
    logic [W+7:0]     scaled;

    // One restoring division step: remainder stays below the phase length
    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_fit = rem_dbl >= {1'b0, len_reg};
    assign rem_sub = rem_dbl - {1'b0, len_reg};

    // Upper half folds to u = 2 - 2t, which never exceeds one
    assign u_full      = FX_TWO - {1'b0, quo_reg, 1'b0};
    assign mul_operand = quo_reg[FRACTION_BITS-1] ? u_full[W-1:0] : W'(quo_reg);

    // One shift-add step of the squarer, multiplier bits leave at the bottom
    assign prod_sum = {1'b0, prod_reg[2*W-1:W]} + (prod_reg[0] ? {1'b0, mul_reg} : '0);

    // Ease value from the square, then scale by 255 as shift and subtract
    assign e_low    = W'(prod_reg >> (FRACTION_BITS - 1));
    assign e_high   = FX_ONE - W'(prod_reg >> (FRACTION_BITS + 1));
    assign ease_val = lower_reg ? e_low : e_high;
    assign fade_val = fade_out_reg ? (FX_ONE - ease_val) : ease_val;
    assign scaled   = {fade_val, 8'b0} - (W + 8)'(fade_val);

    // Sequence divide, square and scale
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
        end else begin
            // Flag the answer for one cycle after the scale step
            done_reg <= (state_reg == E_SCALE);
            unique case (state_reg)
                E_IDLE: begin
                    if (cmd.start) begin
                        rem_reg      <= cmd.pos;
                        len_reg      <= cmd.len;
                        fade_out_reg <= cmd.fade_out;
                        cnt_reg      <= CNT_W'(FRACTION_BITS - 1);
                        state_reg    <= E_DIV;
                    end
                end
                E_DIV: begin
                    rem_reg <= rem_fit ? rem_sub[PHASE_W-1:0] : rem_dbl[PHASE_W-1:0];
                    quo_reg <= {quo_reg[FRACTION_BITS-2:0], rem_fit};
                    if (cnt_reg == '0) begin
                        state_reg <= E_PREP;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                E_PREP: begin
                    lower_reg <= !quo_reg[FRACTION_BITS-1];
                    mul_reg   <= mul_operand;
                    prod_reg  <= {{W{1'b0}}, mul_operand};
                    cnt_reg   <= CNT_W'(W - 1);
                    state_reg <= E_MUL;
                end
                E_MUL: begin
                    prod_reg <= {prod_sum, prod_reg[W-1:1]};
                    if (cnt_reg == '0) begin
                        state_reg <= E_SCALE;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                E_SCALE: begin
                    alpha_reg <= scaled[FRACTION_BITS +: ALPHA_W];
                    state_reg <= E_IDLE;
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.alpha = alpha_reg;

endmodule

// File: rtl/core/eased_fade_envelope.sv
// Top level of the eased fade envelope: register file, phase sequencer, result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  s_       | s_valid / s_ready    | s_data: action, delta_ticks
//  m_       | m_valid / m_ready    | m_data: alpha, active
//  cfg_     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// An enable beat or an advance while stopped passes accept, decode and load.
// An advance while running tests the phases in order, one at a time; a fade
// then waits on the serial ease unit (one quotient bit, then one
// multiplier bit per cycle), which divides, squares and scales.
// One beat is worked at a time; s_ready is high again as soon as the result
// sits in the output register, even while that result waits for m_ready.
// Reset is synchronous, active low, and clears registers, state and time.
module eased_fade_envelope #(
    parameter int unsigned TIME_BITS     = efe_pkg::TIME_BITS_DEF,
    parameter int unsigned FRACTION_BITS = efe_pkg::FRACTION_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  efe_pkg::in_beat_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output efe_pkg::out_beat_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [efe_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [efe_pkg::PHASE_W-1:0]         cfg_data
);
    import efe_pkg::*;

    localparam int unsigned CMP_W = (TIME_BITS > END_W) ? TIME_BITS : END_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_PHASE,
        S_EASE,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_DELAY,
        PH_FADE_IN,
        PH_HOLD,
        PH_FADE_OUT
    } phase_t;

    state_t                  state_reg;
    phase_t                  phase_reg;
    logic [PHASE_W-1:0]      start_delay_reg;
    logic [PHASE_W-1:0]      fade_in_reg;
    logic [PHASE_W-1:0]      hold_reg;
    logic [PHASE_W-1:0]      fade_out_reg;
    logic                    play_once_reg;
    logic [TIME_BITS-1:0]    elapsed_reg;
    logic                    running_reg;
    logic [ALPHA_W-1:0]      last_alpha_reg;
    logic                    action_reg;
    logic [DELTA_W-1:0]      delta_reg;
    logic [END_W-1:0]        base_reg;
    logic                    m_valid_reg;
    out_beat_t               m_data_reg;
    ease_cmd_t               ease_cmd_reg;

    ease_rsp_t               ease_rsp;
    logic [TIME_BITS:0]      elapsed_sum;
    logic [TIME_BITS-1:0]    elapsed_next;
    logic [PHASE_W-1:0]      phase_len;
    logic [END_W-1:0]        phase_end;
    logic                    phase_hit;
    logic [CMP_W-1:0]        phase_pos;
    logic                    out_free;
    logic                    out_load;
    logic                    ease_go;

    // Saturating advance of elapsed time
    assign elapsed_sum  = {1'b0, elapsed_reg} + (TIME_BITS + 1)'(delta_reg);
    assign elapsed_next = elapsed_sum[TIME_BITS] ? '1 : elapsed_sum[TIME_BITS-1:0];

    // Length of the phase under test
    always_comb begin
        unique case (phase_reg)
            PH_DELAY:    phase_len = start_delay_reg;
            PH_FADE_IN:  phase_len = fade_in_reg;
            PH_HOLD:     phase_len = hold_reg;
            PH_FADE_OUT: phase_len = fade_out_reg;
            default:     phase_len = '0;
        endcase
    end

    // Half-open phase test and position inside the phase
    assign phase_end = base_reg + END_W'(phase_len);
    assign phase_hit = CMP_W'(elapsed_reg) < CMP_W'(phase_end);
    assign phase_pos = CMP_W'(elapsed_reg) - CMP_W'(base_reg);

    // Start the ease unit when a fade phase holds the elapsed time
    assign ease_go = (state_reg == S_PHASE) && phase_hit &&
                     ((phase_reg == PH_FADE_IN) || (phase_reg == PH_FADE_OUT));

    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = (state_reg == S_DONE) && out_free;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    efe_ease #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_ease (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (ease_cmd_reg),
        .rsp    (ease_rsp)
    );

    // Sequencer, configuration registers and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            phase_reg          <= PH_DELAY;
            start_delay_reg    <= '0;
            fade_in_reg        <= '0;
            hold_reg           <= '0;
            fade_out_reg       <= '0;
            play_once_reg      <= 1'b0;
            elapsed_reg        <= '0;
            running_reg        <= 1'b0;
            last_alpha_reg     <= '0;
            m_valid_reg        <= 1'b0;
            ease_cmd_reg.start <= 1'b0;
        end else begin
            ease_cmd_reg.start <= ease_go;

            // Load a new result, or drop the one taken
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Register writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_START_DELAY: start_delay_reg <= cfg_data;
                    CFG_FADE_IN:     fade_in_reg     <= cfg_data;
                    CFG_HOLD:        hold_reg        <= cfg_data;
                    CFG_FADE_OUT:    fade_out_reg    <= cfg_data;
                    CFG_PLAY_ONCE:   play_once_reg   <= cfg_data[0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        action_reg <= s_data.action;
                        delta_reg  <= s_data.delta_ticks;
                        state_reg  <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (action_reg) begin
                        running_reg <= 1'b1;
                        state_reg   <= S_DONE;
                    end else if (!running_reg) begin
                        state_reg <= S_DONE;
                    end else begin
                        elapsed_reg <= elapsed_next;
                        base_reg    <= '0;
                        phase_reg   <= PH_DELAY;
                        state_reg   <= S_PHASE;
                    end
                end
                S_PHASE: begin
                    if (phase_hit) begin
                        unique case (phase_reg)
                            PH_DELAY: begin
                                last_alpha_reg <= '0;
                                state_reg      <= S_DONE;
                            end
                            PH_HOLD: begin
                                last_alpha_reg <= '1;
                                state_reg      <= S_DONE;
                            end
                            PH_FADE_IN, PH_FADE_OUT: begin
                                ease_cmd_reg.fade_out <= (phase_reg == PH_FADE_OUT);
                                ease_cmd_reg.pos      <= phase_pos[PHASE_W-1:0];
                                ease_cmd_reg.len      <= phase_len;
                                state_reg             <= S_EASE;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end else if (phase_reg == PH_FADE_OUT) begin
                        // Envelope finished: stop and rewind unless played once
                        last_alpha_reg <= '0;
                        running_reg    <= 1'b0;
                        if (!play_once_reg) begin
                            elapsed_reg <= '0;
                        end
                        state_reg <= S_DONE;
                    end else begin
                        base_reg  <= phase_end;
                        phase_reg <= phase_t'(phase_reg + 2'd1);
                    end
                end
                S_EASE: begin
                    if (ease_rsp.done) begin
                        last_alpha_reg <= ease_rsp.alpha;
                        state_reg      <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        m_data_reg.alpha  <= last_alpha_reg;
                        m_data_reg.active <= running_reg;
                        state_reg         <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // The ease unit answers only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        ease_rsp.done |-> (state_reg == S_EASE))
        else $error("ease answer outside the ease wait");

    // A fade position always lies inside its phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        ease_cmd_reg.start |-> (ease_cmd_reg.pos < ease_cmd_reg.len))
        else $error("fade position not below phase length");

    // Passing the end of the fade out stops the envelope
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PHASE && phase_reg == PH_FADE_OUT && !phase_hit)
        |=> (!running_reg && last_alpha_reg == '0))
        else $error("envelope still running after its end");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for the eased fade envelope: stimulus, prediction and result checks.
module tb;
    import efe_pkg::*;

    localparam logic        ACT_ADVANCE  = 1'b0;
    localparam logic        ACT_ENABLE   = 1'b1;
    localparam int unsigned FRAC         = 16;
    localparam logic [63:0] FX_ONE       = 64'd1 << FRAC;
    localparam logic [63:0] FX_HALF      = 64'd1 << (FRAC - 1);
    localparam logic [63:0] TIME_MAX     = (64'd1 << 32) - 64'd1;
    localparam logic [23:0] LEN_MAX      = 24'hFFFFFF;
    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned PHASE_ITEMS  = 48;
    localparam int unsigned SETTLE       = 60;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned QUIET_LIMIT  = 4000;

    // Clock, reset and DUT ports
    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_beat_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_beat_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [PHASE_W-1:0]     cfg_data  = '0;

    always #1 aclk = ~aclk;

    eased_fade_envelope i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: register copies and envelope state
    logic [23:0] reg_delay    = '0;
    logic [23:0] reg_fade_in  = '0;
    logic [23:0] reg_hold     = '0;
    logic [23:0] reg_fade_out = '0;
    logic        reg_once     = 1'b0;
    logic [63:0] env_elapsed  = '0;
    logic        env_running  = 1'b0;
    logic [7:0]  env_alpha    = '0;

    in_beat_t    beat_queue[$];
    out_beat_t   opacity_due[$];
    out_beat_t   want_beat;

    int unsigned n_popped     = 0;
    int unsigned n_accepted   = 0;
    int unsigned n_results    = 0;
    int unsigned n_errors     = 0;
    int unsigned n_cfg        = 0;
    int unsigned n_fading     = 0;
    int unsigned n_finished   = 0;
    int unsigned n_settings   = 0;
    int unsigned send_gap     = 0;
    int unsigned send_calm    = 0;
    int unsigned recv_wait    = 0;
    int unsigned recv_calm    = 0;
    int unsigned quiet        = 0;
    logic        long_hold_req = 1'b0;
    logic        hold_taken    = 1'b0;

    // Append a beat to the pending stimulus
    task automatic queue_beat(input in_beat_t b);
        beat_queue.insert(beat_queue.size(), b);
    endtask

    // Quadratic ease-in-out of pos within len, Q1.16
    function automatic logic [63:0] ease_q16(input logic [63:0] pos, input logic [63:0] len);
        logic [63:0] t;
        logic [63:0] u;
        if (len == 64'd0) return FX_ONE;
        t = (pos << FRAC) / len;
        if (t >= FX_ONE) t = FX_ONE - 64'd1;
        if (t < FX_HALF) return (64'd2 * t * t) >> FRAC;
        u = 64'd2 * FX_ONE - 64'd2 * t;
        return FX_ONE - ((u * u) >> (FRAC + 1));
    endfunction

    function automatic logic [7:0] to_alpha(input logic [63:0] e);
        logic [63:0] a;
        a = (64'd255 * e) >> FRAC;
        return (a > 64'd255) ? 8'd255 : a[7:0];
    endfunction

    // Advance the envelope by one beat and queue the opacity it should report
    task automatic predict_opacity(input in_beat_t b);
        logic [63:0] delta;
        logic [63:0] end_delay;
        logic [63:0] end_in;
        logic [63:0] end_hold;
        logic [63:0] end_out;
        logic [7:0]  a;
        out_beat_t   o;
        if (b.action == ACT_ENABLE) begin
            env_running = 1'b1;
        end else if (env_running) begin
            delta = 64'(b.delta_ticks);
            if (delta > TIME_MAX - env_elapsed) env_elapsed = TIME_MAX;
            else env_elapsed = env_elapsed + delta;
            end_delay = 64'(reg_delay);
            end_in    = end_delay + 64'(reg_fade_in);
            end_hold  = end_in + 64'(reg_hold);
            end_out   = end_hold + 64'(reg_fade_out);
            if (env_elapsed < end_delay) begin
                a = 8'd0;
            end else if (env_elapsed < end_in) begin
                a = to_alpha(ease_q16(env_elapsed - end_delay, 64'(reg_fade_in)));
            end else if (env_elapsed < end_hold) begin
                a = 8'd255;
            end else if (env_elapsed < end_out) begin
                a = to_alpha(FX_ONE - ease_q16(env_elapsed - end_hold, 64'(reg_fade_out)));
            end else begin
                a = 8'd0;
                env_running = 1'b0;
                n_finished++;
                if (!reg_once) env_elapsed = '0;
            end
            env_alpha = a;
        end
        o.alpha  = env_alpha;
        o.active = env_running;
        opacity_due.insert(opacity_due.size(), o);
    endtask

    // Idle length: mostly short, a few long, with stretches of none
    function automatic int unsigned idle_len(inout int unsigned calm);
        int unsigned r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(16, 48);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic in_beat_t make_beat(input logic action, input logic [15:0] delta);
        in_beat_t b;
        b.action      = action;
        b.delta_ticks = delta;
        return b;
    endfunction

    // Phase length: mostly short, some zero, now and then a full 24-bit value
    function automatic logic [23:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 4) return 24'd0;
        if (r < 14) return 24'($urandom_range(1, 60));
        return 24'($urandom_range(0, 32'hFFFFFF));
    endfunction

    // Advance step sized to the current envelope, with occasional wide values
    function automatic logic [15:0] pick_delta();
        logic [63:0] total;
        logic [63:0] dmax;
        total = 64'(reg_delay) + 64'(reg_fade_in) + 64'(reg_hold) + 64'(reg_fade_out);
        dmax  = total / 64'd6 + 64'd2;
        if (dmax > 64'd65535) dmax = 64'd65535;
        if ($urandom_range(0, 19) == 0) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 32'(dmax)));
    endfunction

    // Register write over the configuration channel
    task automatic write_reg(input cfg_index_t idx, input logic [23:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [23:0] d, input logic [23:0] fi,
                             input logic [23:0] h, input logic [23:0] fo, input logic once);
        write_reg(CFG_START_DELAY, d);
        write_reg(CFG_FADE_IN, fi);
        write_reg(CFG_HOLD, h);
        write_reg(CFG_FADE_OUT, fo);
        write_reg(CFG_PLAY_ONCE, {23'd0, once});
        n_settings++;
    endtask

    // Wait until every beat is sent and every result is back, then settle
    task automatic drain();
        while (beat_queue.size() != 0 || n_popped != n_accepted || opacity_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Mirror register writes into the predictor
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            n_cfg++;
            case (cfg_index)
                CFG_START_DELAY: reg_delay    = cfg_data;
                CFG_FADE_IN:     reg_fade_in  = cfg_data;
                CFG_HOLD:        reg_hold     = cfg_data;
                CFG_FADE_OUT:    reg_fade_out = cfg_data;
                CFG_PLAY_ONCE:   reg_once     = cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input driver: predict on accept, then offer the next beat after a gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_opacity(s_data);
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (beat_queue.size() > 0) begin
                    s_data  <= beat_queue.pop_front();
                    s_valid <= 1'b1;
                    n_popped++;
                    send_gap = idle_len(send_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare against the oldest prediction, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (opacity_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result beat: alpha=%0d active=%0b",
                                 m_data.alpha, m_data.active);
                end else begin
                    want_beat = opacity_due.pop_front();
                    if (m_data.alpha !== want_beat.alpha ||
                        m_data.active !== want_beat.active) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"result %0d mismatch: expected alpha=%0d active=%0b,",
                                      " got alpha=%0d active=%0b"},
                                     n_results, want_beat.alpha, want_beat.active,
                                     m_data.alpha, m_data.active);
                    end
                    if (want_beat.alpha != 8'd0 && want_beat.alpha != 8'd255) n_fading++;
                end
                recv_wait = idle_len(recv_calm);
            end
            if (long_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                recv_wait  = LONG_HOLD;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else if (quiet == QUIET_LIMIT) begin
                $display("[eased_fade_envelope] ERROR");
                $finish;
            end else begin
                quiet++;
            end
        end
    end

    // Stimulus
    initial begin
        int unsigned n_formed;
        int unsigned phase;
        int unsigned phase_items;
        int unsigned r;
        int unsigned n;
        int unsigned n2;
        logic [23:0] d;
        logic [23:0] fi;
        logic [23:0] h;
        logic [23:0] fo;
        logic        once;

        n_formed = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: advance while stopped, enable, then done at once
        queue_beat(make_beat(ACT_ADVANCE, 16'hFFFF));
        queue_beat(make_beat(ACT_ENABLE, 16'hFFFF));
        queue_beat(make_beat(ACT_ADVANCE, 16'd0));
        drain();

        // Short envelope stepped one tick at a time across every phase boundary
        write_all(24'd2, 24'd4, 24'd3, 24'd5, 1'b0);
        queue_beat(make_beat(ACT_ENABLE, 16'd0));
        queue_beat(make_beat(ACT_ENABLE, 16'h5A5A));
        repeat (14) queue_beat(make_beat(ACT_ADVANCE, 16'd1));
        queue_beat(make_beat(ACT_ADVANCE, 16'd7));
        drain();

        // Play once: elapsed is kept, so the next enable ends on its first advance
        write_reg(CFG_PLAY_ONCE, 24'd1);
        queue_beat(make_beat(ACT_ENABLE, 16'd0));
        queue_beat(make_beat(ACT_ADVANCE, 16'hFFFF));
        queue_beat(make_beat(ACT_ENABLE, 16'd0));
        queue_beat(make_beat(ACT_ADVANCE, 16'd0));
        drain();

        // Random phases, each with its own settings
        for (phase = 0; n_formed < RANDOM_ITEMS; phase++) begin
            if (phase == 3) begin
                d = LEN_MAX; fi = LEN_MAX; h = LEN_MAX; fo = LEN_MAX; once = 1'b1;
            end else if (phase == 6) begin
                d = '0; fi = '0; h = '0; fo = '0; once = 1'b0;
            end else if (phase == 8) begin
                d = '0; fi = LEN_MAX; h = '0; fo = 24'd1; once = 1'b0;
            end else begin
                d = pick_len(); fi = pick_len(); h = pick_len(); fo = pick_len();
                once = 1'($urandom_range(0, 1));
            end
            write_all(d, fi, h, fo, once);
            // Let the result side sit still while beats pile up
            if (phase == 1) long_hold_req = 1'b1;

            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    // well-formed: enable followed by a run of advances
                    queue_beat(make_beat(ACT_ENABLE, 16'($urandom_range(0, 65535))));
                    n = $urandom_range(3, 30);
                    repeat (n) queue_beat(make_beat(ACT_ADVANCE, pick_delta()));
                    phase_items += n + 1;
                end else if (r < 9) begin
                    // noise: random actions and deltas
                    n = $urandom_range(1, 6);
                    repeat (n)
                        queue_beat(make_beat(1'($urandom_range(0, 1)),
                                             16'($urandom_range(0, 65535))));
                    phase_items += n;
                end else begin
                    // broken: re-enable in the middle of a run
                    n  = $urandom_range(1, 5);
                    n2 = $urandom_range(1, 5);
                    queue_beat(make_beat(ACT_ENABLE, 16'd0));
                    repeat (n) queue_beat(make_beat(ACT_ADVANCE, pick_delta()));
                    queue_beat(make_beat(ACT_ENABLE, 16'hFFFF));
                    repeat (n2) queue_beat(make_beat(ACT_ADVANCE, pick_delta()));
                    phase_items += n + n2 + 2;
                end
            end
            n_formed += phase_items;
            drain();
        end

        drain();
        if (opacity_due.size() != 0) n_errors += opacity_due.size();

        $display("run covered %0d input beats and %0d results over %0d settings",
                 n_accepted, n_results, n_settings);
        $display("%0d register writes, %0d results inside a fade, %0d envelopes ended, %0d failures",
                 n_cfg, n_fading, n_finished, n_errors);
        if (n_errors == 0) begin
            $display("[eased_fade_envelope] OK");
        end else begin
            $display("[eased_fade_envelope] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/efe_pkg.sv
rtl/core/efe_ease.sv
rtl/core/eased_fade_envelope.sv
sim/tb.sv
